// ===== rtl/core/tes_pkg.sv =====
package tes_pkg;

	// Widths and stage counts of the pipelined square root and the restoring dividers.
	localparam int RAD_W      = 64;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int SQ_STAGES  = ROOT_W;
	localparam int DIV_W      = 76;
	localparam int DVS_W      = 32;
	localparam int DIV_STAGES = DIV_W;

	typedef struct packed {
		logic signed [19:0] x_first;
		logic signed [19:0] y_first;
		logic signed [19:0] x_second;
		logic signed [19:0] y_second;
		logic [23:0]        area;
		logic [23:0]        modulus;
		logic signed [23:0] thermal_strain;
	} elem_t;

	typedef struct packed {
		logic signed [63:0] stiff_cc;
		logic signed [63:0] stiff_cs;
		logic signed [63:0] stiff_ss;
		logic signed [63:0] load_x;
		logic signed [63:0] load_y;
		logic               zero_length;
	} result_t;

endpackage

// ===== rtl/core/tes_if.sv =====
interface tes_elem_if import tes_pkg::*;;
	logic  valid;
	logic  ready;
	elem_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tes_result_if import tes_pkg::*;;
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/truss_element_stiffness_unit.sv =====
// An accepted request passes the s1..s4 stages, the square root, the dividend stage,
// the dividers and p1..p5 before its result is loaded into the output register.
// Throughput: one request per cycle; the whole pipeline advances together and
// holds while the output register keeps a result that has not been taken.
// The depth is set by the 32-stage square root and the 76-stage dividers.
// Reset (arst_n low, asynchronous) clears all valid bits and the output valid.
module truss_element_stiffness_unit import tes_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	tes_elem_if.sink     elem,
	tes_result_if.source result
);

	// Stage map: s1..s4 prepare differences, squares and products; the square
	// root gives Lq; the sd stage forms the three dividends; three dividers
	// give |c|, |s| and k; p1..p5 cap, multiply in 32-bit pieces and round.
	localparam int PRE_STAGES  = 4;
	localparam int POST_STAGES = 5;
	localparam int NST = PRE_STAGES + SQ_STAGES + 1 + DIV_STAGES + POST_STAGES;

	localparam logic [DIV_W-1:0] ONE_Q30 = DIV_W'(64'h4000_0000);
	localparam logic [62:0]      SAT_POS = '1;

	// Side data that rides alongside the square root.
	typedef struct packed {
		logic [19:0] adx;
		logic [19:0] ady;
		logic [47:0] ae;
		logic [63:0] m;
		logic        xneg;
		logic        yneg;
		logic        aneg;
		logic        zero;
	} sqsb_t;

	// Side data that rides alongside the dividers and the final stages.
	typedef struct packed {
		logic [63:0] m;
		logic        xneg;
		logic        yneg;
		logic        aneg;
		logic        zero;
	} dvsb_t;

	logic    adv;
	logic    vld_s [NST];
	logic    out_vld_q;
	result_t out_data_q;

	// The pipeline moves whenever the output register is free or being read.
	assign adv        = !out_vld_q || result.ready;
	assign elem.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) vld_s[i] <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= elem.valid;
			for (int i = 1; i < NST; i++) vld_s[i] <= vld_s[i-1];
			out_vld_q <= vld_s[NST-1];
		end
	end

	// Stage 1: coordinate differences, their magnitudes, and |alpha|.
	logic [20:0] dx_c, dy_c;
	logic [23:0] tv_c;
	logic [19:0] adx_s1, ady_s1;
	logic        xneg_s1, yneg_s1, aneg_s1;
	logic [23:0] amag_s1, area_s1, modu_s1;

	always_comb begin
		dx_c = {elem.data.x_first[19], elem.data.x_first}
			- {elem.data.x_second[19], elem.data.x_second};
		dy_c = {elem.data.y_first[19], elem.data.y_first}
			- {elem.data.y_second[19], elem.data.y_second};
		tv_c = elem.data.thermal_strain;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xneg_s1 <= dx_c[20];
			yneg_s1 <= dy_c[20];
			aneg_s1 <= tv_c[23];
			adx_s1  <= dx_c[20] ? 20'(-dx_c) : dx_c[19:0];
			ady_s1  <= dy_c[20] ? 20'(-dy_c) : dy_c[19:0];
			amag_s1 <= tv_c[23] ? 24'(~tv_c + 24'd1) : tv_c;
			area_s1 <= elem.data.area;
			modu_s1 <= elem.data.modulus;
		end
	end

	// Stage 2: squares of the differences and A*E.
	logic [39:0] dx2_s2, dy2_s2;
	logic [47:0] ae_s2;
	logic [19:0] adx_s2, ady_s2;
	logic [23:0] amag_s2;
	logic        xneg_s2, yneg_s2, aneg_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			dx2_s2  <= adx_s1 * adx_s1;
			dy2_s2  <= ady_s1 * ady_s1;
			ae_s2   <= area_s1 * modu_s1;
			adx_s2  <= adx_s1;
			ady_s2  <= ady_s1;
			amag_s2 <= amag_s1;
			xneg_s2 <= xneg_s1;
			yneg_s2 <= yneg_s1;
			aneg_s2 <= aneg_s1;
		end
	end

	// Stage 3: squared length, and A*E*|alpha| as two partial products of 24-bit halves of A*E.
	logic [40:0] l2_s3;
	logic [47:0] pmh_s3, pml_s3, ae_s3;
	logic [19:0] adx_s3, ady_s3;
	logic        xneg_s3, yneg_s3, aneg_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			l2_s3   <= 41'(dx2_s2) + 41'(dy2_s2);
			pmh_s3  <= ae_s2[47:24] * amag_s2;
			pml_s3  <= ae_s2[23:0] * amag_s2;
			ae_s3   <= ae_s2;
			adx_s3  <= adx_s2;
			ady_s3  <= ady_s2;
			xneg_s3 <= xneg_s2;
			yneg_s3 <= yneg_s2;
			aneg_s3 <= aneg_s2;
		end
	end

	// Stage 4: thermal magnitude m = round(A*E*|alpha| / 2^7) and the
	// coincident-node flag.
	logic [71:0] msum_c;
	logic [40:0] l2_s4;
	sqsb_t       sb_s4;

	assign msum_c = {pmh_s3, 24'b0} + 72'(pml_s3) + 72'd64;

	always_ff @(posedge clk) begin
		if (adv) begin
			l2_s4      <= l2_s3;
			sb_s4.adx  <= adx_s3;
			sb_s4.ady  <= ady_s3;
			sb_s4.ae   <= ae_s3;
			sb_s4.m    <= msum_c[70:7];
			sb_s4.xneg <= xneg_s3;
			sb_s4.yneg <= yneg_s3;
			sb_s4.aneg <= aneg_s3;
			sb_s4.zero <= (l2_s3 == '0);
		end
	end

	// Lq = floor(sqrt(L2 * 2^22)), L in Q.11.
	logic [ROOT_W-1:0] lq;
	sqsb_t             sqsb_q [SQ_STAGES];

	tes_sqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.rad  ({1'b0, l2_s4, 22'b0}),
		.root (lq)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sqsb_q[0] <= sb_s4;
			for (int i = 1; i < SQ_STAGES; i++) sqsb_q[i] <= sqsb_q[i-1];
		end
	end

	// Dividend stage: each dividend carries Lq/2 so the quotient rounds.
	sqsb_t             sq_end;
	logic [DIV_W-1:0]  half_c;
	logic [DIV_W-1:0]  numc_sd, nums_sd, numk_sd;
	logic [DVS_W-1:0]  lq_sd;
	dvsb_t             sb_sd;

	assign sq_end = sqsb_q[SQ_STAGES-1];
	assign half_c = DIV_W'(lq[ROOT_W-1:1]);

	always_ff @(posedge clk) begin
		if (adv) begin
			numc_sd    <= DIV_W'({sq_end.adx, 41'b0}) + half_c;
			nums_sd    <= DIV_W'({sq_end.ady, 41'b0}) + half_c;
			numk_sd    <= DIV_W'({sq_end.ae, 27'b0}) + half_c;
			lq_sd      <= lq;
			sb_sd.m    <= sq_end.m;
			sb_sd.xneg <= sq_end.xneg;
			sb_sd.yneg <= sq_end.yneg;
			sb_sd.aneg <= sq_end.aneg;
			sb_sd.zero <= sq_end.zero;
		end
	end

	logic [DIV_W-1:0] qc, qs, qk;
	dvsb_t            dvsb_q [DIV_STAGES];

	tes_div u_div_c (.clk(clk), .en(adv), .num(numc_sd), .dvs(lq_sd), .quo(qc));
	tes_div u_div_s (.clk(clk), .en(adv), .num(nums_sd), .dvs(lq_sd), .quo(qs));
	tes_div u_div_k (.clk(clk), .en(adv), .num(numk_sd), .dvs(lq_sd), .quo(qk));

	always_ff @(posedge clk) begin
		if (adv) begin
			dvsb_q[0] <= sb_sd;
			for (int i = 1; i < DIV_STAGES; i++) dvsb_q[i] <= dvsb_q[i-1];
		end
	end

	// P1: cap the direction cosines at one and saturate k.
	logic [30:0] cq_p1, sq_p1;
	logic [62:0] kq_p1;
	dvsb_t       sb_p1;

	always_ff @(posedge clk) begin
		if (adv) begin
			cq_p1 <= (qc > ONE_Q30) ? ONE_Q30[30:0] : qc[30:0];
			sq_p1 <= (qs > ONE_Q30) ? ONE_Q30[30:0] : qs[30:0];
			kq_p1 <= (|qk[DIV_W-1:63]) ? SAT_POS : qk[62:0];
			sb_p1 <= dvsb_q[DIV_STAGES-1];
		end
	end

	// P2: direction products, and m times |c| and |s| in 32-bit halves of m.
	logic [60:0] ab_p2 [3];
	logic [62:0] lxl_p2, lxh_p2, lyl_p2, lyh_p2;
	logic [62:0] kq_p2;
	dvsb_t       sb_p2;

	always_ff @(posedge clk) begin
		if (adv) begin
			ab_p2[0] <= 61'(cq_p1 * cq_p1);
			ab_p2[1] <= 61'(cq_p1 * sq_p1);
			ab_p2[2] <= 61'(sq_p1 * sq_p1);
			lxl_p2   <= sb_p1.m[31:0] * cq_p1;
			lxh_p2   <= sb_p1.m[63:32] * cq_p1;
			lyl_p2   <= sb_p1.m[31:0] * sq_p1;
			lyh_p2   <= sb_p1.m[63:32] * sq_p1;
			kq_p2    <= kq_p1;
			sb_p2    <= sb_p1;
		end
	end

	// P3: k times each direction product as four partial products of 32-bit pieces;
	// thermal loads are rounded and saturated here.
	logic [95:0] lxs_c, lys_c;
	logic [65:0] lxr_c, lyr_c;
	logic [63:0] pp_p3 [3][4];
	logic [62:0] lx_p3, ly_p3;
	dvsb_t       sb_p3;

	always_comb begin
		lxs_c = {1'b0, lxh_p2, 32'b0} + 96'(lxl_p2) + (96'd1 << 29);
		lys_c = {1'b0, lyh_p2, 32'b0} + 96'(lyl_p2) + (96'd1 << 29);
		lxr_c = lxs_c[95:30];
		lyr_c = lys_c[95:30];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int t = 0; t < 3; t++) begin
				pp_p3[t][0] <= kq_p2[31:0] * ab_p2[t][31:0];
				pp_p3[t][1] <= 64'(kq_p2[31:0] * ab_p2[t][60:32]);
				pp_p3[t][2] <= 64'(kq_p2[62:32] * ab_p2[t][31:0]);
				pp_p3[t][3] <= 64'(kq_p2[62:32] * ab_p2[t][60:32]);
			end
			lx_p3 <= (|lxr_c[65:63]) ? SAT_POS : lxr_c[62:0];
			ly_p3 <= (|lyr_c[65:63]) ? SAT_POS : lyr_c[62:0];
			sb_p3 <= sb_p2;
		end
	end

	// P4: pair up the partial products.
	logic [96:0] lo_p4 [3];
	logic [96:0] hi_p4 [3];
	logic [62:0] lx_p4, ly_p4;
	dvsb_t       sb_p4;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int t = 0; t < 3; t++) begin
				lo_p4[t] <= 97'(pp_p3[t][0]) + {1'b0, pp_p3[t][1], 32'b0};
				hi_p4[t] <= 97'(pp_p3[t][2]) + {1'b0, pp_p3[t][3], 32'b0};
			end
			lx_p4 <= lx_p3;
			ly_p4 <= ly_p3;
			sb_p4 <= sb_p3;
		end
	end

	// P5: final sum and round by 2^60.
	logic [127:0] tot_c [3];
	logic [63:0]  st_p5 [3];
	logic [62:0]  lx_p5, ly_p5;
	dvsb_t        sb_p5;

	always_comb begin
		for (int t = 0; t < 3; t++) begin
			tot_c[t] = 128'(lo_p4[t]) + (128'(hi_p4[t]) << 32) + (128'd1 << 59);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int t = 0; t < 3; t++) st_p5[t] <= tot_c[t][123:60];
			lx_p5 <= lx_p4;
			ly_p5 <= ly_p4;
			sb_p5 <= sb_p4;
		end
	end

	// Output register: signs, and all zeros for coincident nodes.
	logic [63:0] lxm_c, lym_c;

	assign lxm_c = {1'b0, lx_p5};
	assign lym_c = {1'b0, ly_p5};

	always_ff @(posedge clk) begin
		if (adv) begin
			if (sb_p5.zero) begin
				out_data_q.stiff_cc    <= '0;
				out_data_q.stiff_cs    <= '0;
				out_data_q.stiff_ss    <= '0;
				out_data_q.load_x      <= '0;
				out_data_q.load_y      <= '0;
				out_data_q.zero_length <= 1'b1;
			end else begin
				out_data_q.stiff_cc    <= st_p5[0];
				out_data_q.stiff_cs    <= (sb_p5.xneg ^ sb_p5.yneg) ? -st_p5[1] : st_p5[1];
				out_data_q.stiff_ss    <= st_p5[2];
				out_data_q.load_x      <= (sb_p5.aneg ^ sb_p5.xneg) ? -lxm_c : lxm_c;
				out_data_q.load_y      <= (sb_p5.aneg ^ sb_p5.yneg) ? -lym_c : lym_c;
				out_data_q.zero_length <= 1'b0;
			end
		end
	end

	assign result.valid = out_vld_q;
	assign result.data  = out_data_q;

	// A coincident-node result carries nothing but the flag.
	a_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.zero_length |->
			result.data.stiff_cc == '0 && result.data.stiff_cs == '0 &&
			result.data.stiff_ss == '0 && result.data.load_x == '0 &&
			result.data.load_y == '0)
		else $error("zero-length result has nonzero terms");

	// The diagonal stiffness terms are never negative.
	a_diag_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !result.data.stiff_cc[63] && !result.data.stiff_ss[63])
		else $error("negative diagonal stiffness");

	// The pipeline holds while the output register waits.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s[NST-1]) && $stable(sb_p5))
		else $error("pipeline moved during stall");

endmodule

// ===== rtl/core/tes_sqrt.sv =====
module tes_sqrt import tes_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [RAD_W-1:0]  rad,
	output logic [ROOT_W-1:0] root
);

	// One result bit per stage, classic digit-by-digit square root.
	logic [RAD_W-1:0]  rad_s  [SQ_STAGES];
	logic [ROOT_W+1:0] rem_s  [SQ_STAGES];
	logic [ROOT_W-1:0] root_s [SQ_STAGES];

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
		logic [RAD_W-1:0]  rad_in;
		logic [ROOT_W+1:0] rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [ROOT_W+3:0] acc;
		logic [ROOT_W+3:0] trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign rad_in  = rad;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		always_comb begin
			acc   = {rem_in, rad_in[RAD_W-1 -: 2]};
			trial = {2'b00, root_in, 2'b01};
			ge    = (acc >= trial);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= {rad_in[RAD_W-3:0], 2'b00};
				rem_s[k]  <= ge ? (ROOT_W+2)'(acc - trial) : acc[ROOT_W+1:0];
				root_s[k] <= {root_in[ROOT_W-2:0], ge};
			end
		end
	end

	assign root = root_s[SQ_STAGES-1];

endmodule

// ===== rtl/core/tes_div.sv =====
module tes_div import tes_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [DIV_W-1:0] num,
	input  logic [DVS_W-1:0] dvs,
	output logic [DIV_W-1:0] quo
);

	// Restoring division, one quotient bit per stage. The dividend shifts out
	// at the top while the quotient bits shift in at the bottom.
	logic [DIV_W-1:0] nq_s  [DIV_STAGES];
	logic [DVS_W-1:0] rem_s [DIV_STAGES];
	logic [DVS_W-1:0] dvs_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [DIV_W-1:0] nq_in;
		logic [DVS_W-1:0] rem_in;
		logic [DVS_W-1:0] dvs_in;
		logic [DVS_W:0]   acc;
		logic             ge;

		if (k == 0) begin : g_first
			assign nq_in  = num;
			assign rem_in = '0;
			assign dvs_in = dvs;
		end else begin : g_next
			assign nq_in  = nq_s[k-1];
			assign rem_in = rem_s[k-1];
			assign dvs_in = dvs_s[k-1];
		end

		always_comb begin
			acc = {rem_in, nq_in[DIV_W-1]};
			ge  = (acc >= {1'b0, dvs_in});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[k]  <= {nq_in[DIV_W-2:0], ge};
				rem_s[k] <= ge ? DVS_W'(acc - {1'b0, dvs_in}) : acc[DVS_W-1:0];
				dvs_s[k] <= dvs_in;
			end
		end
	end

	assign quo = nq_s[DIV_STAGES-1];

endmodule

// ===== tb/sv/truss_element_stiffness_unit_tb.sv =====
`timescale 1ns / 100ps

module truss_element_stiffness_unit_tb;
	import tes_pkg::*;

	localparam int      CLK_HALF     = 5;
	localparam int      PIPE_DEPTH   = 118;
	localparam int      RANDOM_ITEMS = 2000;
	localparam longint  RUN_LIMIT_NS = 64'd4_000_000;

	localparam logic [63:0] STIFF_SAT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] UNIT_DIR  = 64'h4000_0000;

	// One row of the directed table. When the expected result can be read off
	// by hand it is typed into the row; otherwise the predictor supplies it.
	typedef struct {
		elem_t   elem;
		bit      typed;
		result_t result;
	} elem_row_t;

	logic clk;
	logic arst_n;

	tes_elem_if   elem_ch();
	tes_result_if result_ch();

	truss_element_stiffness_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.elem   (elem_ch.sink),
		.result (result_ch.source)
	);

	result_t   pending_results[$];
	elem_row_t directed_rows[$];
	int        send_idle_pct;
	int        recv_idle_pct;
	int        recv_hold_asks;
	int        recv_hold_done;
	int        recv_hold_cycles;
	int        error_count;
	int        requests_sent;
	int        results_checked;
	int        zero_length_seen;
	int        saturated_seen;

	// The clock runs with separate high and low phases.
	always begin
		clk = 1'b1;
		#CLK_HALF;
		clk = 1'b0;
		#CLK_HALF;
	end

	// Integer square root by the digit-by-digit method, floor of the true root.
	function automatic logic [63:0] isqrt(input logic [63:0] radicand);
		logic [63:0] root;
		logic [63:0] bitpos;
		root   = '0;
		bitpos = 64'h4000_0000_0000_0000;
		while (bitpos > radicand)
			bitpos = bitpos >> 2;
		while (bitpos != 0) begin
			if (radicand >= root + bitpos) begin
				radicand = radicand - (root + bitpos);
				root     = (root >> 1) + bitpos;
			end else begin
				root = root >> 1;
			end
			bitpos = bitpos >> 2;
		end
		return root;
	endfunction

	// Global stiffness entries and thermal load of one bar element. Every
	// intermediate is held in 128 bits so that no product wraps; rounding is
	// half away from zero on magnitudes, with the sign applied last.
	function automatic result_t bar_stiffness(input elem_t e);
		result_t         r;
		logic signed [20:0] dx;
		logic signed [20:0] dy;
		logic [127:0]    adx, ady, len_sq, len_q, cos_q, sin_q;
		logic [127:0]    ae, k_q, m_q, alpha_mag, t;
		logic            x_neg, y_neg, a_neg;
		dx        = 21'(e.x_first) - 21'(e.x_second);
		dy        = 21'(e.y_first) - 21'(e.y_second);
		x_neg     = dx[20];
		y_neg     = dy[20];
		a_neg     = e.thermal_strain[23];
		adx       = x_neg ? 128'(-dx) : 128'(dx);
		ady       = y_neg ? 128'(-dy) : 128'(dy);
		alpha_mag = a_neg ? 128'(-25'(e.thermal_strain)) : 128'(e.thermal_strain);
		len_sq    = adx * adx + ady * ady;
		r         = '0;
		if (len_sq == 0) begin
			r.zero_length = 1'b1;
			return r;
		end
		len_q = 128'(isqrt(64'(len_sq << 22)));
		cos_q = ((adx << 41) + (len_q >> 1)) / len_q;
		sin_q = ((ady << 41) + (len_q >> 1)) / len_q;
		if (cos_q > UNIT_DIR) cos_q = UNIT_DIR;
		if (sin_q > UNIT_DIR) sin_q = UNIT_DIR;
		ae  = 128'(e.area) * 128'(e.modulus);
		k_q = ((ae << 27) + (len_q >> 1)) / len_q;
		if (k_q > STIFF_SAT) k_q = STIFF_SAT;
		m_q = (ae * alpha_mag + 128'd64) >> 7;

		r.stiff_cc = 64'((k_q * (cos_q * cos_q) + (128'd1 << 59)) >> 60);
		t          = (k_q * (cos_q * sin_q) + (128'd1 << 59)) >> 60;
		r.stiff_cs = (x_neg != y_neg) ? -64'(t) : 64'(t);
		r.stiff_ss = 64'((k_q * (sin_q * sin_q) + (128'd1 << 59)) >> 60);
		t          = (m_q * cos_q + (128'd1 << 29)) >> 30;
		if (t > STIFF_SAT) t = STIFF_SAT;
		r.load_x   = (a_neg != x_neg) ? -64'(t) : 64'(t);
		t          = (m_q * sin_q + (128'd1 << 29)) >> 30;
		if (t > STIFF_SAT) t = STIFF_SAT;
		r.load_y   = (a_neg != y_neg) ? -64'(t) : 64'(t);
		return r;
	endfunction

	function automatic elem_t make_elem(input int x1, input int y1, input int x2,
			input int y2, input int a, input int e_mod, input int alpha);
		elem_t e;
		e.x_first        = 20'(x1);
		e.y_first        = 20'(y1);
		e.x_second       = 20'(x2);
		e.y_second       = 20'(y2);
		e.area           = 24'(a);
		e.modulus        = 24'(e_mod);
		e.thermal_strain = 24'(alpha);
		return e;
	endfunction

	function automatic void add_row(input elem_t e, input bit typed, input result_t r);
		elem_row_t row;
		row.elem   = e;
		row.typed  = typed;
		row.result = r;
		directed_rows.push_back(row);
	endfunction

	// Random element. Half the draws are full-range; the rest use short bars, axis-aligned bars,
	// coincident nodes or extreme material values so each corner gets hit.
	function automatic elem_t random_elem();
		elem_t e;
		int    shape;
		e     = elem_t'(152'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom}));
		shape = $urandom_range(0, 9);
		unique case (shape)
			0: begin
				e.x_second = e.x_first;
				e.y_second = e.y_first;
			end
			1: begin
				e.x_second = e.x_first + 20'($urandom_range(0, 6)) - 20'd3;
				e.y_second = e.y_first + 20'($urandom_range(0, 6)) - 20'd3;
			end
			2: begin
				e.area    = 24'hFF_FFFF;
				e.modulus = 24'hFF_FFFF;
			end
			3: begin
				if ($urandom_range(0, 1)) e.x_second = e.x_first;
				else e.y_second = e.y_first;
			end
			4: e.thermal_strain = $urandom_range(0, 1) ? 24'h80_0000 : 24'h7F_FFFF;
			default: begin
			end
		endcase
		return e;
	endfunction

	task automatic check_result(input result_t want, input result_t got);
		if (got.stiff_cc !== want.stiff_cc) begin
			$error("stiff_cc: expected %0d, got %0d", want.stiff_cc, got.stiff_cc);
			error_count++;
		end
		if (got.stiff_cs !== want.stiff_cs) begin
			$error("stiff_cs: expected %0d, got %0d", want.stiff_cs, got.stiff_cs);
			error_count++;
		end
		if (got.stiff_ss !== want.stiff_ss) begin
			$error("stiff_ss: expected %0d, got %0d", want.stiff_ss, got.stiff_ss);
			error_count++;
		end
		if (got.load_x !== want.load_x) begin
			$error("load_x: expected %0d, got %0d", want.load_x, got.load_x);
			error_count++;
		end
		if (got.load_y !== want.load_y) begin
			$error("load_y: expected %0d, got %0d", want.load_y, got.load_y);
			error_count++;
		end
		if (got.zero_length !== want.zero_length) begin
			$error("zero_length: expected %0b, got %0b", want.zero_length,
				got.zero_length);
			error_count++;
		end
	endtask

	// Offers one request, idling first as the current sender rate says, and
	// holds it until the block takes it. Valid gets one assignment per edge.
	task automatic send_request(input elem_t e, input bit typed, input result_t typed_result);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			elem_ch.valid <= 1'b0;
			elem_ch.data  <= elem_t'(152'({$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom}));
			@(posedge clk);
		end
		elem_ch.valid <= 1'b1;
		elem_ch.data  <= e;
		@(posedge clk);
		while (!elem_ch.ready)
			@(posedge clk);
		// The request was taken at this edge, so its result is now owed.
		pending_results.push_back(typed ? typed_result : bar_stiffness(e));
		requests_sent++;
	endtask

	task automatic drain_pipeline();
		elem_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// The receiver either honors a long hold-off, counted here in cycles, or
	// stalls at random at the current receiver rate. A new hold-off starts
	// whenever the stimulus asks for one more than has been served.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready  <= 1'b0;
			recv_hold_cycles <= 0;
			recv_hold_done   <= 0;
		end else if (recv_hold_done != recv_hold_asks) begin
			result_ch.ready  <= 1'b0;
			recv_hold_cycles <= 3 * PIPE_DEPTH;
			recv_hold_done   <= recv_hold_asks;
		end else if (recv_hold_cycles > 0) begin
			result_ch.ready  <= 1'b0;
			recv_hold_cycles <= recv_hold_cycles - 1;
		end else begin
			result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Every result taken by the receiver is matched against the oldest
	// prediction still waiting.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request waiting for it");
				error_count++;
			end else begin
				check_result(pending_results.pop_front(), result_ch.data);
				results_checked++;
				if (result_ch.data.zero_length) zero_length_seen++;
				if (result_ch.data.stiff_cc == STIFF_SAT) saturated_seen++;
			end
		end
	end

	// Runaway guard, far beyond the slowest legal run.
	initial begin
		#RUN_LIMIT_NS;
		$display("truss_element_stiffness_unit regression: fail");
		$finish;
	end

	initial begin
		result_t zero_res;
		result_t coinc_res;
		elem_t   e;

		recv_hold_asks   = 0;
		error_count      = 0;
		requests_sent    = 0;
		results_checked  = 0;
		zero_length_seen = 0;
		saturated_seen   = 0;
		send_idle_pct    = 21;
		recv_idle_pct    = 67;
		elem_ch.valid    = 1'b0;
		elem_ch.data     = '0;
		arst_n           = 1'b0;
		zero_res         = '0;
		coinc_res        = '0;
		coinc_res.zero_length = 1'b1;

		// Directed table. Coincident nodes give zeros with the flag set, and a zero area or modulus
		// gives plain zeros; the rest go through the predictor.
		add_row(make_elem(0, 0, 0, 0, 1, 1, 1), 1, coinc_res);
		add_row(make_elem(524287, -524288, 524287, -524288, 16777215, 16777215,
			-8388608), 1, coinc_res);
		add_row(make_elem(-524288, 524287, -524288, 524287, 0, 0, 8388607), 1, coinc_res);
		add_row(make_elem(5, 7, -3, 2, 0, 16777215, 8388607), 1, zero_res);
		add_row(make_elem(5, 7, -3, 2, 16777215, 0, -8388608), 1, zero_res);
		add_row(make_elem(1, 0, 0, 0, 1000, 2000, 4096), 0, zero_res);
		add_row(make_elem(0, 1, 0, 0, 1000, 2000, -4096), 0, zero_res);
		add_row(make_elem(0, 0, 1, 0, 1000, 2000, 4096), 0, zero_res);
		add_row(make_elem(0, 0, 0, 1, 1000, 2000, -4096), 0, zero_res);
		add_row(make_elem(3, 4, 0, 0, 500, 700, 1234), 0, zero_res);
		add_row(make_elem(-3, 4, 0, 0, 500, 700, -1234), 0, zero_res);
		add_row(make_elem(3, -4, 0, 0, 500, 700, 1234), 0, zero_res);
		add_row(make_elem(-3, -4, 0, 0, 500, 700, -1234), 0, zero_res);
		add_row(make_elem(524287, 524287, -524288, -524288, 16777215, 16777215,
			8388607), 0, zero_res);
		add_row(make_elem(-524288, -524288, 524287, 524287, 16777215, 16777215,
			-8388608), 0, zero_res);
		// A unit-length bar with the largest A*E drives k into saturation.
		add_row(make_elem(1, 0, 0, 0, 16777215, 16777215, -8388608), 0, zero_res);
		add_row(make_elem(0, -1, 0, 0, 16777215, 16777215, 8388607), 0, zero_res);
		add_row(make_elem(1, 1, 0, 0, 16777215, 16777215, 8388607), 0, zero_res);
		add_row(make_elem(524287, 0, -524288, 0, 1, 1, 1), 0, zero_res);
		add_row(make_elem(0, 524287, 0, -524288, 1, 1, -1), 0, zero_res);
		add_row(make_elem(12345, -6789, -2222, 31415, 99999, 123456, 0), 0, zero_res);
		add_row(make_elem(-1, -1, 1, 1, 16777215, 1, 8388607), 0, zero_res);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].elem, directed_rows[i].typed,
				directed_rows[i].result);

		// Random traffic in three phases of idling. In the first phase the
		// receiver holds off for a long stretch so the pipeline fills and
		// backs up into the input; before the last phase the sender waits
		// until every owed result has arrived.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300)
				recv_hold_asks = recv_hold_asks + 1;
			if (n == RANDOM_ITEMS / 3) begin
				send_idle_pct = 67;
				recv_idle_pct = 21;
			end
			if (n == 2 * RANDOM_ITEMS / 3) begin
				drain_pipeline();
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			e = random_elem();
			send_request(e, 0, zero_res);
		end

		drain_pipeline();
		repeat (PIPE_DEPTH + 20) @(posedge clk);

		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			error_count++;
		end
		$display("Sent %0d elements and checked %0d results through stalls and a backed-up pipe.",
			requests_sent, results_checked);
		$display("Coincident-node results: %0d; saturated stiffness results: %0d.",
			zero_length_seen, saturated_seen);
		if (error_count == 0) begin
			$display("truss_element_stiffness_unit regression: pass");
		end else begin
			$display("truss_element_stiffness_unit regression: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/tes_pkg.sv
rtl/core/tes_if.sv
rtl/core/tes_sqrt.sv
rtl/core/tes_div.sv
rtl/core/truss_element_stiffness_unit.sv
tb/sv/truss_element_stiffness_unit_tb.sv
